/* rtl/core/cgr_pkg.sv */
// Shared types, constants and codes for the color gradient ramp unit.
// No dependencies.
`timescale 1ns / 1ps

package cgr_pkg;

  localparam int POS_W       = 17;      // position, 65536 = 1.0
  localparam int CH_W        = 8;       // one color channel
  localparam int NUM_CH      = 4;       // r, g, b, a
  localparam int GW_W        = 13;      // ramp width register
  localparam int IDX_W       = 12;      // sample index
  localparam int FRAC_W      = 16;      // interpolation fraction / quotient bits
  localparam int TOTAL_W     = 5;       // reported point total
  localparam int MAX_POINTS_DEF = 16;

  localparam logic [POS_W-1:0] ONE_POS   = POS_W'(65536);
  localparam logic [GW_W-1:0]  GW_RESET  = GW_W'(256);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FEW  = 2'd1,
    STS_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVP,
    ST_SCAN,
    ST_FRAC,
    ST_DIVT,
    ST_MIX,
    ST_DONE
  } state_e;

  typedef logic [CH_W-1:0] color_t [NUM_CH];

  typedef struct packed {
    logic [POS_W-1:0]             pos;
    logic [NUM_CH-1:0][CH_W-1:0]  col;
  } point_t;

endpackage

/* rtl/core/cgr_cell.sv */
// One table slot of the sorted point chain; loads the new point or its left neighbor.
// Depends on cgr_pkg.
`timescale 1ns / 1ps

module cgr_cell (
  input  logic           clk_i,
  input  logic           ins_en_i,     // insert word accepted, table not full
  input  logic           valid_i,      // this slot holds a point
  input  cgr_pkg::point_t new_pt_i,
  input  cgr_pkg::point_t prev_pt_i,
  input  logic           prev_valid_i,
  input  logic           prev_le_i,    // left neighbor stays in place
  output cgr_pkg::point_t pt_o,
  output logic           le_o
);
  import cgr_pkg::*;

  point_t pt_q, pt_d;
  logic   take_new, take_prev;

  assign le_o      = valid_i && (pt_q.pos <= new_pt_i.pos);
  assign take_new  = ins_en_i && !le_o && prev_le_i;
  assign take_prev = ins_en_i && prev_valid_i && !prev_le_i;

  always_comb begin
    pt_d = pt_q;
    if (take_new) begin
      pt_d = new_pt_i;
    end else if (take_prev) begin
      pt_d = prev_pt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign pt_o = pt_q;

endmodule

/* rtl/core/cgr_div.sv */
// Restoring divider, one quotient bit per cycle, for num < den.
// Depends on cgr_pkg.
`timescale 1ns / 1ps

module cgr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cgr_pkg::POS_W-1:0] num_i,
  input  logic [cgr_pkg::POS_W-1:0] den_i,
  output logic                      done_o,
  output logic [cgr_pkg::FRAC_W-1:0] quot_o
);
  import cgr_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W);

  logic [POS_W-1:0]  rem_q, rem_d, den_q;
  logic [FRAC_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [POS_W:0]    r2, diff;
  logic              ge;

  assign r2   = {rem_q, 1'b0};
  assign diff = r2 - {1'b0, den_q};
  assign ge   = r2 >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      cnt_d  = CNT_W'(FRAC_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[POS_W-1:0] : r2[POS_W-1:0];
      quot_d = {quot_q[FRAC_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* rtl/core/color_gradient_ramp_unit.sv */
// Top level of the color gradient ramp unit: point chain, scan, divider, mixer.
// Depends on cgr_pkg, cgr_cell, cgr_div.
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Carries
// in       to block   in_valid_i/in_stall_o  opcode, point, sample index
// out      from block out_valid_o/out_stall_i status, rgba, point total
// cfg      to block   cfg_we_i               gradient width
//
// Clear, insert and unused opcodes load the result register when accepted: the chain shifts in parallel.
// A sample runs the index division (16 quotient bits), a scan of up to MAX_POINTS
// points, the fraction division, then setup, mixing and the output load; a clamped
// index or a whole-step fraction skips its division. Both divisions use the shared
// one-bit-per-cycle divider.
// Reset clears the point count, the width register (to 256) and all control.
// A word is taken only while no sample is in flight; an output stall holds the
// result register and a new word waits until it can be written.

module color_gradient_ramp_unit #(
  parameter int MAX_POINTS = cgr_pkg::MAX_POINTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cgr_pkg::GW_W-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 opcode_i,
  input  logic [cgr_pkg::POS_W-1:0]  point_position_i,
  input  logic [cgr_pkg::CH_W-1:0]   point_red_i,
  input  logic [cgr_pkg::CH_W-1:0]   point_green_i,
  input  logic [cgr_pkg::CH_W-1:0]   point_blue_i,
  input  logic [cgr_pkg::CH_W-1:0]   point_alpha_i,
  input  logic [cgr_pkg::IDX_W-1:0]  sample_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [cgr_pkg::CH_W-1:0]   red_o,
  output logic [cgr_pkg::CH_W-1:0]   green_o,
  output logic [cgr_pkg::CH_W-1:0]   blue_o,
  output logic [cgr_pkg::CH_W-1:0]   alpha_o,
  output logic [cgr_pkg::TOTAL_W-1:0] point_total_o
);
  import cgr_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IW    = $clog2(MAX_POINTS);

  state_e state_q, state_d;

  logic [GW_W-1:0]  width_q;
  logic [GW_W-1:0]  w_eff;
  logic [CNT_W-1:0] count_q, count_d;

  logic   in_acc, out_free, out_load;
  op_e    op;
  point_t new_pt;

  // point chain
  point_t          cell_pt [MAX_POINTS];
  logic [MAX_POINTS-1:0] cell_le, cell_valid;
  logic            ins_en;

  // sample datapath
  logic [POS_W-1:0] p_q, p_d, lp_q, lp_d, rp_q, rp_d, t_q, t_d;
  logic [POS_W-1:0] q_eff, rp_eff, frac_num, frac_den, div_num, div_den;
  logic [NUM_CH-1:0][CH_W-1:0] lcol_q, lcol_d, rcol_q, rcol_d, rcol_eff;
  logic [CH_W-1:0]  mix_q [NUM_CH];
  logic [CH_W-1:0]  mix_d [NUM_CH];
  logic             has_l_q, has_l_d, has_r_q, has_r_d;
  logic [IW-1:0]    scan_q, scan_d;
  point_t           rd_pt;
  logic             scan_last;

  logic              div_start, div_done;
  logic [FRAC_W-1:0] div_quot;

  // output register
  logic             ov_q, ov_d;
  status_e          osts_q, osts_d;
  logic [NUM_CH-1:0][CH_W-1:0] ocol_q, ocol_d;
  logic [TOTAL_W-1:0] otot_q, otot_d;

  assign op     = op_e'(opcode_i);
  assign w_eff  = (width_q == '0) ? GW_W'(1) : width_q;
  assign new_pt = '{pos: point_position_i,
                    col: {point_alpha_i, point_blue_i, point_green_i, point_red_i}};

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ins_en     = in_acc && (op == OP_INSERT) &&
                      (count_q < CNT_W'(MAX_POINTS));

  // chain: slot k takes the new point where the "stays" flags turn off,
  // and every slot after it whose left neighbor is occupied takes that neighbor
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    assign cell_valid[k] = CNT_W'(k) < count_q;
    if (k == 0) begin : g_head
      cgr_cell u_cell (
        .clk_i       (clk_i),
        .ins_en_i    (ins_en),
        .valid_i     (cell_valid[k]),
        .new_pt_i    (new_pt),
        .prev_pt_i   (new_pt),
        .prev_valid_i(1'b0),
        .prev_le_i   (1'b1),
        .pt_o        (cell_pt[k]),
        .le_o        (cell_le[k])
      );
    end else begin : g_body
      cgr_cell u_cell (
        .clk_i       (clk_i),
        .ins_en_i    (ins_en),
        .valid_i     (cell_valid[k]),
        .new_pt_i    (new_pt),
        .prev_pt_i   (cell_pt[k-1]),
        .prev_valid_i(cell_valid[k-1]),
        .prev_le_i   (cell_le[k-1]),
        .pt_o        (cell_pt[k]),
        .le_o        (cell_le[k])
      );
    end
  end

  // scan read port: first point counts as 0, last as 1.0
  assign rd_pt     = cell_pt[scan_q];
  assign scan_last = CNT_W'(scan_q) == (count_q - 1'b1);
  assign q_eff     = (scan_q == '0) ? '0 : (scan_last ? ONE_POS : rd_pt.pos);

  assign rp_eff   = has_r_q ? rp_q : lp_q;
  assign rcol_eff = has_r_q ? rcol_q : lcol_q;
  assign frac_num = p_q - lp_q;
  assign frac_den = rp_eff - lp_q;

  assign div_num = (state_q == ST_IDLE) ? POS_W'(sample_index_i) : frac_num;
  assign div_den = (state_q == ST_IDLE) ? POS_W'(w_eff) : frac_den;

  cgr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // channel = (a*65536 + (b-a)*t + 32768) >> 16; stays within 0..255
  always_comb begin
    logic signed [CH_W:0]        dlt;
    logic signed [CH_W+POS_W+1:0] acc;
    for (int c = 0; c < NUM_CH; c++) begin
      dlt = $signed({1'b0, rcol_eff[c]}) - $signed({1'b0, lcol_q[c]});
      acc = $signed({2'b00, lcol_q[c], 16'h0000}) + dlt * $signed({1'b0, t_q}) +
            $signed((CH_W+POS_W+2)'(32768));
      mix_d[c] = acc[CH_W+FRAC_W-1:FRAC_W];
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    div_start = 1'b0;
    p_d       = p_q;
    lp_d      = lp_q;
    rp_d      = rp_q;
    t_d       = t_q;
    lcol_d    = lcol_q;
    rcol_d    = rcol_q;
    has_l_d   = has_l_q;
    has_r_d   = has_r_q;
    scan_d    = scan_q;
    out_load  = 1'b0;
    osts_d    = STS_OK;
    ocol_d    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          case (op)
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_INSERT: begin
              if (ins_en) begin
                count_d = count_q + 1'b1;
              end else begin
                osts_d = STS_FULL;
              end
            end
            OP_SAMPLE: begin
              if (count_q < CNT_W'(2)) begin
                osts_d = STS_FEW;
              end else begin
                out_load = 1'b0;
                scan_d   = '0;
                has_l_d  = 1'b0;
                has_r_d  = 1'b0;
                if (GW_W'(sample_index_i) >= w_eff) begin
                  p_d     = ONE_POS;
                  state_d = ST_SCAN;
                end else begin
                  div_start = 1'b1;
                  state_d   = ST_DIVP;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIVP: begin
        if (div_done) begin
          p_d     = POS_W'(div_quot);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (q_eff <= p_q && (!has_l_q || q_eff > lp_q)) begin
          has_l_d = 1'b1;
          lp_d    = q_eff;
          lcol_d  = rd_pt.col;
        end else if (q_eff >= p_q) begin
          has_r_d = 1'b1;
          rp_d    = q_eff;
          rcol_d  = rd_pt.col;
        end
        if (scan_last || (has_r_d && !has_r_q)) begin
          state_d = ST_FRAC;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_FRAC: begin
        if (rp_eff > lp_q) begin
          if (frac_num >= frac_den) begin
            t_d     = ONE_POS;
            state_d = ST_MIX;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIVT;
          end
        end else begin
          t_d     = '0;
          state_d = ST_MIX;
        end
      end
      ST_DIVT: begin
        if (div_done) begin
          t_d     = POS_W'(div_quot);
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          for (int c = 0; c < NUM_CH; c++) begin
            ocol_d[c] = mix_q[c];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    ov_d   = out_load ? 1'b1 : (ov_q && out_stall_i);
    otot_d = TOTAL_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      width_q <= GW_RESET;
      ov_q    <= 1'b0;
      has_l_q <= 1'b0;
      has_r_q <= 1'b0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      has_l_q <= has_l_d;
      has_r_q <= has_r_d;
      scan_q  <= scan_d;
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    lp_q   <= lp_d;
    rp_q   <= rp_d;
    t_q    <= t_d;
    lcol_q <= lcol_d;
    rcol_q <= rcol_d;
    if (state_q == ST_MIX) begin
      mix_q <= mix_d;
    end
    if (out_load) begin
      osts_q <= osts_d;
      ocol_q <= ocol_d;
      otot_q <= otot_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign status_o      = osts_q;
  assign red_o         = ocol_q[0];
  assign green_o       = ocol_q[1];
  assign blue_o        = ocol_q[2];
  assign alpha_o       = ocol_q[3];
  assign point_total_o = otot_q;

  // table never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count above table size");

  // divider results only arrive while a division is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVP || state_q == ST_DIVT))
    else $error("divider done outside a division state");

  // a scan only runs on a table of two or more points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (count_q >= CNT_W'(2)))
    else $error("scan with fewer than two points");

  // the table stays put while a sample is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> $stable(count_q))
    else $error("point count changed during a sample");

endmodule
